// ===== hdl/lcst_pkg.sv =====
`timescale 1ns / 1ps

package lcst_pkg;

    // Widths of the per-leg fields on the channels are fixed at four legs.
    localparam int unsigned MAX_LEGS = 4;

    // Per-leg contact mode, held one-hot inside the block.
    typedef enum logic [4:0] {
        MODE_STANCE = 5'b00001,
        MODE_SWING  = 5'b00010,
        MODE_EARLY  = 5'b00100,
        MODE_LATE   = 5'b01000,
        MODE_LOST   = 5'b10000
    } t_mode;

    // Mode codes as they appear in the leg_modes field.
    localparam logic [2:0] MODE_CODE_STANCE = 3'd0;
    localparam logic [2:0] MODE_CODE_SWING  = 3'd1;
    localparam logic [2:0] MODE_CODE_EARLY  = 3'd2;
    localparam logic [2:0] MODE_CODE_LATE   = 3'd3;
    localparam logic [2:0] MODE_CODE_LOST   = 3'd4;

    // Target source selector codes.
    localparam logic [2:0] TSRC_PLAN       = 3'd0;
    localparam logic [2:0] TSRC_KEEP       = 3'd1;
    localparam logic [2:0] TSRC_LAST_PLAN  = 3'd2;
    localparam logic [2:0] TSRC_EARLY_HOLD = 3'd3;
    localparam logic [2:0] TSRC_SLIP_HOLD  = 3'd4;

    // Wrench source selector codes.
    localparam logic [1:0] WSRC_KEEP   = 2'd0;
    localparam logic [1:0] WSRC_ZERO   = 2'd1;
    localparam logic [1:0] WSRC_FUTURE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EARLY_EN   = 2'd0;
    localparam logic [1:0] CFG_LATE_EN    = 2'd1;
    localparam logic [1:0] CFG_LOST_EN    = 2'd2;
    localparam logic [1:0] CFG_RESCHED_EN = 2'd3;

    typedef struct packed {
        logic early_en;
        logic late_en;
        logic lost_en;
        logic resched_en;
    } t_cfg;

    typedef struct packed {
        t_mode      mode;
        logic       contact;
        logic [2:0] tsrc;
        logic [1:0] wsrc;
        logic       ev_regained;
        logic       ev_early;
        logic       ev_late;
        logic       ev_lost;
        logic       ev_swing_idle;
        logic       cap_world;
        logic       cap_body;
    } t_leg_res;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        unique case (m)
            MODE_SWING: c = MODE_CODE_SWING;
            MODE_EARLY: c = MODE_CODE_EARLY;
            MODE_LATE:  c = MODE_CODE_LATE;
            MODE_LOST:  c = MODE_CODE_LOST;
            default:    c = MODE_CODE_STANCE;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/lcst_in_if.sv =====
`timescale 1ns / 1ps

interface lcst_in_if #(
    parameter int unsigned PROG_W = 9
);
    logic              valid;
    logic              ready;
    logic [3:0]        planned_contact;
    logic [3:0]        sensed_contact;
    logic [PROG_W-1:0] swing_progress_leg0;
    logic [PROG_W-1:0] swing_progress_leg1;
    logic [PROG_W-1:0] swing_progress_leg2;
    logic [PROG_W-1:0] swing_progress_leg3;
    logic [3:0]        swing_idle;

    modport source (
        output valid, planned_contact, sensed_contact, swing_progress_leg0,
               swing_progress_leg1, swing_progress_leg2, swing_progress_leg3, swing_idle,
        input  ready
    );
    modport sink (
        input  valid, planned_contact, sensed_contact, swing_progress_leg0,
               swing_progress_leg1, swing_progress_leg2, swing_progress_leg3, swing_idle,
        output ready
    );
endinterface

// ===== hdl/lcst_out_if.sv =====
`timescale 1ns / 1ps

interface lcst_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] leg_modes;
    logic [3:0]  contact_out;
    logic [11:0] target_source;
    logic [7:0]  wrench_source;
    logic [3:0]  regained_events;
    logic [3:0]  early_events;
    logic [3:0]  late_events;
    logic [3:0]  lost_events;
    logic [3:0]  swing_not_started_events;
    logic [3:0]  capture_world_hold;
    logic [3:0]  capture_body_hold;

    modport source (
        output valid, leg_modes, contact_out, target_source, wrench_source,
               regained_events, early_events, late_events, lost_events,
               swing_not_started_events, capture_world_hold, capture_body_hold,
        input  ready
    );
    modport sink (
        input  valid, leg_modes, contact_out, target_source, wrench_source,
               regained_events, early_events, late_events, lost_events,
               swing_not_started_events, capture_world_hold, capture_body_hold,
        output ready
    );
endinterface

// ===== hdl/lcst_leg.sv =====
`timescale 1ns / 1ps

// Next mode and derived selectors for one leg.
module lcst_leg #(
    parameter int unsigned PROGRESS_FRAC_BITS = 8
) (
    input  lcst_pkg::t_mode                 i_mode,
    input  lcst_pkg::t_cfg                  i_cfg,
    input  logic                            i_plan,
    input  logic                            i_sense,
    input  logic                            i_idle,
    input  logic [PROGRESS_FRAC_BITS:0]     i_prog,
    output lcst_pkg::t_leg_res              o_res
);

    localparam int unsigned          PROG_W = PROGRESS_FRAC_BITS + 1;
    localparam logic [PROG_W-1:0]    HALF   = PROG_W'(1) << (PROGRESS_FRAC_BITS - 1);

    lcst_pkg::t_mode n_mode;
    logic            past_half;

    assign past_half = (i_prog > HALF);

    always_comb begin
        o_res = '0;
        n_mode = i_mode;
        unique case (i_mode)
            lcst_pkg::MODE_LATE, lcst_pkg::MODE_LOST: begin
                if (i_sense) begin
                    n_mode = i_plan ? lcst_pkg::MODE_STANCE : lcst_pkg::MODE_SWING;
                    o_res.ev_regained = 1'b1;
                end else if (i_cfg.resched_en && !i_plan) begin
                    n_mode = lcst_pkg::MODE_SWING;
                    o_res.ev_regained = 1'b1;
                end
            end
            lcst_pkg::MODE_EARLY: begin
                if (i_plan) begin
                    n_mode = lcst_pkg::MODE_STANCE;
                end
            end
            lcst_pkg::MODE_SWING: begin
                if (i_cfg.early_en && !i_plan && i_sense && past_half) begin
                    n_mode = lcst_pkg::MODE_EARLY;
                    o_res.ev_early  = 1'b1;
                    o_res.cap_world = 1'b1;
                end else if (i_cfg.late_en && i_plan && !i_sense) begin
                    n_mode = lcst_pkg::MODE_LATE;
                    o_res.ev_late  = 1'b1;
                    o_res.cap_body = 1'b1;
                end else if (i_plan) begin
                    n_mode = lcst_pkg::MODE_STANCE;
                end
            end
            default: begin
                // Stance, and any code that cannot arise, behave as stance.
                n_mode = lcst_pkg::MODE_STANCE;
                if (!i_plan) begin
                    n_mode = lcst_pkg::MODE_SWING;
                end else if (i_cfg.lost_en && !i_sense) begin
                    n_mode = lcst_pkg::MODE_LOST;
                    o_res.ev_lost  = 1'b1;
                    o_res.cap_body = 1'b1;
                end
            end
        endcase

        o_res.mode    = n_mode;
        o_res.contact = i_plan;
        unique case (n_mode)
            lcst_pkg::MODE_STANCE: begin
                o_res.tsrc = lcst_pkg::TSRC_PLAN;
                o_res.wsrc = lcst_pkg::WSRC_KEEP;
            end
            lcst_pkg::MODE_SWING: begin
                o_res.wsrc = lcst_pkg::WSRC_ZERO;
                if (i_idle) begin
                    o_res.tsrc          = lcst_pkg::TSRC_LAST_PLAN;
                    o_res.ev_swing_idle = 1'b1;
                end else begin
                    o_res.tsrc = lcst_pkg::TSRC_KEEP;
                end
            end
            lcst_pkg::MODE_EARLY: begin
                o_res.contact = 1'b1;
                o_res.tsrc    = lcst_pkg::TSRC_EARLY_HOLD;
                o_res.wsrc    = lcst_pkg::WSRC_FUTURE;
            end
            default: begin
                o_res.contact = 1'b0;
                o_res.tsrc    = lcst_pkg::TSRC_SLIP_HOLD;
                o_res.wsrc    = lcst_pkg::WSRC_ZERO;
            end
        endcase
    end

endmodule

// ===== hdl/leg_contact_state_tracker_core.sv =====
`timescale 1ns / 1ps

// Leg contact state tracker.
// One input word per control cycle carries, for each leg, the planned and sensed
// contact, the swing progress (unsigned, PROGRESS_FRAC_BITS fraction bits) and the
// swing controller idle flag. One output word comes back for each input word with
// the new per-leg contact modes, the overridden contact vector, target and wrench
// source selectors, event flags and position capture strobes.
// Both channels use valid/ready; a word moves when both are high. The input word
// is registered in the input register, the per-leg mode logic works on it, and the
// result is registered in the output register, from which it is presented. A new
// word is taken every cycle while output words are taken: the input register
// refills in the same cycle that it hands its word to the output register, and the
// mode state is written at that same edge, so the following word already sees it.
// When the receiver stalls the output word holds, the input register fills, and
// input ready then drops until the output word is taken.
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data; the
// user must write them only while no word is in flight, as the block does not
// check it. Reset clears both pipeline registers, sets every leg to stance and
// restores the register defaults (early, late and lost detection on, rescheduling
// off). Legs at or beyond NUM_LEGS read as zero in every field.
module leg_contact_state_tracker_core #(
    parameter int unsigned NUM_LEGS           = 4,
    parameter int unsigned PROGRESS_FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcst_in_if.sink     i_in,
    lcst_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [0:0]  i_cfg_data
);

    localparam int unsigned PROG_W = PROGRESS_FRAC_BITS + 1;
    localparam int unsigned NL     = lcst_pkg::MAX_LEGS;

    lcst_pkg::t_cfg r_cfg;

    // Input register.
    logic              r_s1_valid;
    logic [NL-1:0]     r_s1_plan;
    logic [NL-1:0]     r_s1_sense;
    logic [NL-1:0]     r_s1_idle;
    logic [PROG_W-1:0] r_s1_prog [NL];

    // Output register.
    logic          r_out_valid;
    logic [11:0]   r_leg_modes;
    logic [3:0]    r_contact_out;
    logic [11:0]   r_target_source;
    logic [7:0]    r_wrench_source;
    logic [3:0]    r_regained;
    logic [3:0]    r_early;
    logic [3:0]    r_late;
    logic [3:0]    r_lost;
    logic [3:0]    r_swing_idle;
    logic [3:0]    r_cap_world;
    logic [3:0]    r_cap_body;

    logic out_free;
    logic s1_move;
    logic in_take;

    lcst_pkg::t_leg_res w_res [NL];

    logic [11:0] n_leg_modes;
    logic [3:0]  n_contact_out;
    logic [11:0] n_target_source;
    logic [7:0]  n_wrench_source;
    logic [3:0]  n_regained;
    logic [3:0]  n_early;
    logic [3:0]  n_late;
    logic [3:0]  n_lost;
    logic [3:0]  n_swing_idle;
    logic [3:0]  n_cap_world;
    logic [3:0]  n_cap_body;

    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_move    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.early_en   <= 1'b1;
            r_cfg.late_en    <= 1'b1;
            r_cfg.lost_en    <= 1'b1;
            r_cfg.resched_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lcst_pkg::CFG_EARLY_EN:   r_cfg.early_en   <= i_cfg_data[0];
                lcst_pkg::CFG_LATE_EN:    r_cfg.late_en    <= i_cfg_data[0];
                lcst_pkg::CFG_LOST_EN:    r_cfg.lost_en    <= i_cfg_data[0];
                lcst_pkg::CFG_RESCHED_EN: r_cfg.resched_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_plan    <= i_in.planned_contact;
            r_s1_sense   <= i_in.sensed_contact;
            r_s1_idle    <= i_in.swing_idle;
            r_s1_prog[0] <= i_in.swing_progress_leg0;
            r_s1_prog[1] <= i_in.swing_progress_leg1;
            r_s1_prog[2] <= i_in.swing_progress_leg2;
            r_s1_prog[3] <= i_in.swing_progress_leg3;
        end
    end

    for (genvar g = 0; g < NL; g++) begin : g_leg
        if (g < NUM_LEGS) begin : g_on
            lcst_pkg::t_mode r_mode;

            lcst_leg #(
                .PROGRESS_FRAC_BITS (PROGRESS_FRAC_BITS)
            ) u_leg (
                .i_mode  (r_mode),
                .i_cfg   (r_cfg),
                .i_plan  (r_s1_plan[g]),
                .i_sense (r_s1_sense[g]),
                .i_idle  (r_s1_idle[g]),
                .i_prog  (r_s1_prog[g]),
                .o_res   (w_res[g])
            );

            // The mode advances exactly when its word passes to the output register.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_mode <= lcst_pkg::MODE_STANCE;
                end else if (s1_move) begin
                    r_mode <= w_res[g].mode;
                end
            end
        end else begin : g_off
            assign w_res[g] = '0;
        end
    end

    always_comb begin
        n_leg_modes     = '0;
        n_contact_out   = '0;
        n_target_source = '0;
        n_wrench_source = '0;
        n_regained      = '0;
        n_early         = '0;
        n_late          = '0;
        n_lost          = '0;
        n_swing_idle    = '0;
        n_cap_world     = '0;
        n_cap_body      = '0;
        for (int k = 0; k < NL; k++) begin
            if (k < NUM_LEGS) begin
                n_leg_modes[3*k +: 3]     = lcst_pkg::mode_code(w_res[k].mode);
                n_target_source[3*k +: 3] = w_res[k].tsrc;
                n_wrench_source[2*k +: 2] = w_res[k].wsrc;
                n_contact_out[k]          = w_res[k].contact;
                n_regained[k]             = w_res[k].ev_regained;
                n_early[k]                = w_res[k].ev_early;
                n_late[k]                 = w_res[k].ev_late;
                n_lost[k]                 = w_res[k].ev_lost;
                n_swing_idle[k]           = w_res[k].ev_swing_idle;
                n_cap_world[k]            = w_res[k].cap_world;
                n_cap_body[k]             = w_res[k].cap_body;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_leg_modes     <= n_leg_modes;
            r_contact_out   <= n_contact_out;
            r_target_source <= n_target_source;
            r_wrench_source <= n_wrench_source;
            r_regained      <= n_regained;
            r_early         <= n_early;
            r_late          <= n_late;
            r_lost          <= n_lost;
            r_swing_idle    <= n_swing_idle;
            r_cap_world     <= n_cap_world;
            r_cap_body      <= n_cap_body;
        end
    end

    assign o_out.valid                    = r_out_valid;
    assign o_out.leg_modes                = r_leg_modes;
    assign o_out.contact_out              = r_contact_out;
    assign o_out.target_source            = r_target_source;
    assign o_out.wrench_source            = r_wrench_source;
    assign o_out.regained_events          = r_regained;
    assign o_out.early_events             = r_early;
    assign o_out.late_events              = r_late;
    assign o_out.lost_events              = r_lost;
    assign o_out.swing_not_started_events = r_swing_idle;
    assign o_out.capture_world_hold       = r_cap_world;
    assign o_out.capture_body_hold        = r_cap_body;

endmodule

// ===== hdl/lcst_chk.sv =====
`timescale 1ns / 1ps

module lcst_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [11:0] i_leg_modes,
    input logic [3:0]  i_early,
    input logic [3:0]  i_late,
    input logic [3:0]  i_lost,
    input logic [3:0]  i_cap_world,
    input logic [3:0]  i_cap_body
);

    // A stalled output word stays valid and keeps its leg modes.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_leg_modes)))
        else $error("output word changed while stalled");

    // The world position is latched on exactly the early contact events.
    a_world_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_cap_world == i_early))
        else $error("world capture does not match early events");

    // The body position is latched on exactly the late and lost contact events.
    a_body_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_cap_body == (i_late | i_lost)))
        else $error("body capture does not match late or lost events");

    // A leg raises at most one detection event per word.
    a_event_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (((i_early & i_late) | (i_early & i_lost) | (i_late & i_lost)) == 4'd0))
        else $error("more than one detection event on a leg");

endmodule

bind leg_contact_state_tracker_core lcst_chk u_lcst_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_leg_modes (o_out.leg_modes),
    .i_early     (o_out.early_events),
    .i_late      (o_out.late_events),
    .i_lost      (o_out.lost_events),
    .i_cap_world (o_out.capture_world_hold),
    .i_cap_body  (o_out.capture_body_hold)
);
